// ===== rtl/fls_pkg.sv =====
// package: constants, types and helpers for the frame-linked operand stack
package fls_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int WORD_BITS   = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SUM_W       = ((CNT_W > 8) ? CNT_W : 8) + 1;

  typedef logic [CNT_W-1:0] base_t;

  localparam base_t BASE_NONE = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    MODE_RESET = 3'd0,
    MODE_PUSH  = 3'd1,
    MODE_POP   = 3'd2,
    MODE_TOP   = 3'd3,
    MODE_OPEN  = 3'd4,
    MODE_READ  = 3'd5,
    MODE_WRITE = 3'd6,
    MODE_CLOSE = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_OVER  = 3'd1,
    ERR_UNDER = 3'd2,
    ERR_LOCAL = 3'd3,
    ERR_FRAME = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_WALK,
    ST_WALK_WAIT,
    ST_LOCATE,
    ST_READ_WAIT,
    ST_CLOSE_WAIT
  } state_t;

  function automatic base_t link_to_base(input logic [WORD_BITS-1:0] w);
    base_t b;
    if (w > WORD_BITS'(STACK_DEPTH)) begin
      b = BASE_NONE;
    end else begin
      b = w[CNT_W-1:0];
    end
    return b;
  endfunction

  function automatic logic [WORD_BITS-1:0] base_to_link(input base_t b);
    logic [WORD_BITS-1:0] w;
    if (b == BASE_NONE) begin
      w = {WORD_BITS{1'b1}};
    end else begin
      w = WORD_BITS'(b);
    end
    return w;
  endfunction

endpackage

// ===== rtl/fls_ram.sv =====
// generic single-port ram with registered read
module fls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/frame_linked_operand_stack.sv =====
// top level: operand stack with linked block frames held in one ram
//
// channel   direction  handshake                 payload
// request   in         start high, busy low      mode value local_count frames_below local_number
// result    out        done high for one cycle   read_value error depth
//
// reset, push, any early error: exec; pop, top: exec, read wait; close: exec, close wait
// open frame: exec writes the link, then fill writes one zeroed local per ram write
// local access: a ram read per link in walk/walk wait, then locate; reads add a read wait
// rst clears the count, the frame base and the control; ram contents are not cleared
// a result is on the ports for one cycle while the next request may already be taken
module frame_linked_operand_stack (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   mode,
  input  logic [fls_pkg::WORD_BITS-1:0] value,
  input  logic [7:0]                   local_count,
  input  logic [6:0]                   frames_below,
  input  logic [7:0]                   local_number,
  output logic                         done,
  output logic [fls_pkg::WORD_BITS-1:0] read_value,
  output logic [2:0]                   error,
  output logic [7:0]                   depth
);

  localparam int CNT_W  = fls_pkg::CNT_W;
  localparam int ADDR_W = fls_pkg::ADDR_W;
  localparam int SUM_W  = fls_pkg::SUM_W;
  localparam int WB     = fls_pkg::WORD_BITS;

  fls_pkg::state_t state, state_next;
  fls_pkg::base_t  entry_count, entry_count_next;
  fls_pkg::base_t  frame_base, frame_base_next;
  fls_pkg::base_t  cur, cur_next;
  fls_pkg::mode_t  op_mode;
  logic [WB-1:0]   op_value;
  logic [7:0]      op_count, op_count_next;
  logic [6:0]      op_below, op_below_next;
  logic [7:0]      op_num;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [WB-1:0]     mem_wdata;
  logic [WB-1:0]     mem_rdata;

  logic             res_valid;
  fls_pkg::err_t    res_err;
  logic [WB-1:0]    res_data;
  fls_pkg::err_t    err_reg;

  fls_pkg::base_t   ec_dec, fb_dec, cur_dec;
  logic [SUM_W-1:0] open_sum, local_pos;
  logic             full, empty, open_over, close_bad, walk_bad, num_bad, pos_bad;
  logic             accept;

  fls_ram #(.WIDTH(WB), .DEPTH(fls_pkg::STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy   = (state != fls_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign ec_dec    = entry_count - 1'b1;
  assign fb_dec    = frame_base - 1'b1;
  assign cur_dec   = cur - 1'b1;
  assign open_sum  = SUM_W'(entry_count) + SUM_W'(1) + SUM_W'(op_count);
  assign local_pos = SUM_W'(cur) + SUM_W'(op_num) - SUM_W'(1);

  assign full      = (entry_count >= CNT_W'(fls_pkg::STACK_DEPTH));
  assign empty     = (entry_count == '0);
  assign open_over = (open_sum > SUM_W'(fls_pkg::STACK_DEPTH));
  assign close_bad = (frame_base == fls_pkg::BASE_NONE) || (frame_base == '0) ||
                     (frame_base > entry_count);
  assign walk_bad  = (cur == fls_pkg::BASE_NONE) || (cur == '0) || (cur_dec >= entry_count);
  assign num_bad   = (op_num == '0);
  assign pos_bad   = (cur == fls_pkg::BASE_NONE) || (local_pos >= SUM_W'(entry_count));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fls_pkg::ST_IDLE: begin
        if (accept) state_next = fls_pkg::ST_EXEC;
      end
      fls_pkg::ST_EXEC: begin
        unique case (op_mode)
          fls_pkg::MODE_RESET, fls_pkg::MODE_PUSH: state_next = fls_pkg::ST_IDLE;
          fls_pkg::MODE_POP, fls_pkg::MODE_TOP: begin
            state_next = empty ? fls_pkg::ST_IDLE : fls_pkg::ST_READ_WAIT;
          end
          fls_pkg::MODE_OPEN: begin
            state_next = (open_over || op_count == '0) ? fls_pkg::ST_IDLE : fls_pkg::ST_FILL;
          end
          fls_pkg::MODE_READ, fls_pkg::MODE_WRITE: state_next = fls_pkg::ST_WALK;
          fls_pkg::MODE_CLOSE: begin
            state_next = close_bad ? fls_pkg::ST_IDLE : fls_pkg::ST_CLOSE_WAIT;
          end
          default: state_next = fls_pkg::ST_IDLE;
        endcase
      end
      fls_pkg::ST_FILL: begin
        if (op_count == 8'd1) state_next = fls_pkg::ST_IDLE;
      end
      fls_pkg::ST_WALK: begin
        priority if (op_below == '0) state_next = fls_pkg::ST_LOCATE;
        else if (walk_bad)           state_next = fls_pkg::ST_IDLE;
        else                         state_next = fls_pkg::ST_WALK_WAIT;
      end
      fls_pkg::ST_WALK_WAIT: state_next = fls_pkg::ST_WALK;
      fls_pkg::ST_LOCATE: begin
        priority if (num_bad || pos_bad)          state_next = fls_pkg::ST_IDLE;
        else if (op_mode == fls_pkg::MODE_READ)   state_next = fls_pkg::ST_READ_WAIT;
        else                                      state_next = fls_pkg::ST_IDLE;
      end
      fls_pkg::ST_READ_WAIT, fls_pkg::ST_CLOSE_WAIT: state_next = fls_pkg::ST_IDLE;
      default: state_next = fls_pkg::ST_IDLE;
    endcase
  end

  // datapath, ram access and result
  always_comb begin
    entry_count_next = entry_count;
    frame_base_next  = frame_base;
    cur_next         = cur;
    op_count_next    = op_count;
    op_below_next    = op_below;
    mem_we           = 1'b0;
    mem_addr         = '0;
    mem_wdata        = '0;
    res_valid        = 1'b0;
    res_err          = fls_pkg::ERR_OK;
    res_data         = '0;
    unique case (state)
      fls_pkg::ST_IDLE: begin
        if (accept) begin
          op_count_next = local_count;
          op_below_next = frames_below;
        end
      end
      fls_pkg::ST_EXEC: begin
        unique case (op_mode)
          fls_pkg::MODE_RESET: begin
            entry_count_next = '0;
            res_valid        = 1'b1;
          end
          fls_pkg::MODE_PUSH: begin
            res_valid = 1'b1;
            if (full) begin
              res_err = fls_pkg::ERR_OVER;
            end else begin
              mem_we           = 1'b1;
              mem_addr         = entry_count[ADDR_W-1:0];
              mem_wdata        = op_value;
              entry_count_next = entry_count + 1'b1;
            end
          end
          fls_pkg::MODE_POP, fls_pkg::MODE_TOP: begin
            if (empty) begin
              res_valid = 1'b1;
              res_err   = fls_pkg::ERR_UNDER;
            end else begin
              mem_addr = ec_dec[ADDR_W-1:0];
              if (op_mode == fls_pkg::MODE_POP) entry_count_next = ec_dec;
            end
          end
          fls_pkg::MODE_OPEN: begin
            if (open_over) begin
              res_valid = 1'b1;
              res_err   = fls_pkg::ERR_OVER;
            end else begin
              mem_we           = 1'b1;
              mem_addr         = entry_count[ADDR_W-1:0];
              mem_wdata        = fls_pkg::base_to_link(frame_base);
              entry_count_next = entry_count + 1'b1;
              frame_base_next  = entry_count + 1'b1;
              if (op_count == '0) res_valid = 1'b1;
            end
          end
          fls_pkg::MODE_READ, fls_pkg::MODE_WRITE: begin
            cur_next = frame_base;
          end
          fls_pkg::MODE_CLOSE: begin
            if (close_bad) begin
              res_valid = 1'b1;
              res_err   = fls_pkg::ERR_FRAME;
            end else begin
              mem_addr         = fb_dec[ADDR_W-1:0];
              entry_count_next = fb_dec;
            end
          end
          default: ;
        endcase
      end
      fls_pkg::ST_FILL: begin
        mem_we           = 1'b1;
        mem_addr         = entry_count[ADDR_W-1:0];
        entry_count_next = entry_count + 1'b1;
        op_count_next    = op_count - 1'b1;
        if (op_count == 8'd1) res_valid = 1'b1;
      end
      fls_pkg::ST_WALK: begin
        if (op_below != '0) begin
          if (walk_bad) begin
            res_valid = 1'b1;
            res_err   = fls_pkg::ERR_FRAME;
          end else begin
            mem_addr = cur_dec[ADDR_W-1:0];
          end
        end
      end
      fls_pkg::ST_WALK_WAIT: begin
        cur_next      = fls_pkg::link_to_base(mem_rdata);
        op_below_next = op_below - 1'b1;
      end
      fls_pkg::ST_LOCATE: begin
        priority if (num_bad) begin
          res_valid = 1'b1;
          res_err   = fls_pkg::ERR_LOCAL;
        end else if (pos_bad) begin
          res_valid = 1'b1;
          res_err   = fls_pkg::ERR_FRAME;
        end else begin
          mem_addr = local_pos[ADDR_W-1:0];
          if (op_mode == fls_pkg::MODE_WRITE) begin
            mem_we    = 1'b1;
            mem_wdata = op_value;
            res_valid = 1'b1;
          end
        end
      end
      fls_pkg::ST_READ_WAIT: begin
        res_valid = 1'b1;
        res_data  = mem_rdata;
      end
      fls_pkg::ST_CLOSE_WAIT: begin
        frame_base_next = fls_pkg::link_to_base(mem_rdata);
        res_valid       = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fls_pkg::ST_IDLE;
      entry_count <= '0;
      frame_base  <= fls_pkg::BASE_NONE;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      frame_base  <= frame_base_next;
      done        <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    op_count <= op_count_next;
    op_below <= op_below_next;
    if (accept) begin
      op_mode  <= fls_pkg::mode_t'(mode);
      op_value <= value;
      op_num   <= local_number;
    end
    if (res_valid) begin
      read_value <= (res_err == fls_pkg::ERR_OK) ? res_data : '0;
      err_reg    <= res_err;
      depth      <= 8'(entry_count_next);
    end
  end

  assign error = err_reg;

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(state == fls_pkg::ST_IDLE))
    else $error("result without a request in flight");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(fls_pkg::STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request accepted but block not busy");

  a_error_clears_data: assert property (@(posedge clk) disable iff (rst)
    (done && error != fls_pkg::ERR_OK) |-> (read_value == '0))
    else $error("read value not zero on error");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(done) || $past(accept))
    else $error("back-to-back results without a new request");

endmodule

// ===== sim/stack_op_checker.sv =====
// checker: predicts each stack request's reply and compares it with the block's output
module stack_op_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [2:0]                    mode,
  input  logic [fls_pkg::WORD_BITS-1:0] value,
  input  logic [7:0]                    local_count,
  input  logic [6:0]                    frames_below,
  input  logic [7:0]                    local_number,
  input  logic                          done,
  input  logic [fls_pkg::WORD_BITS-1:0] read_value,
  input  logic [2:0]                    error,
  input  logic [7:0]                    depth,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [fls_pkg::WORD_BITS-1:0] word;
    fls_pkg::err_t                 code;
    logic [7:0]                    level;
  } stack_reply_t;

  logic [fls_pkg::WORD_BITS-1:0] word_mem [fls_pkg::STACK_DEPTH];
  int                            used;
  fls_pkg::base_t                cur_base;
  stack_reply_t                  replies_due [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t stack_op_checker: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic fls_pkg::base_t link_base(input logic [fls_pkg::WORD_BITS-1:0] w);
    return (w > fls_pkg::STACK_DEPTH) ? fls_pkg::BASE_NONE : fls_pkg::base_t'(w);
  endfunction

  // walk the saved links down, then resolve the local to a slot
  function automatic fls_pkg::err_t find_local(input int steps, input int num, output int slot);
    fls_pkg::base_t f = cur_base;
    slot = 0;
    for (int k = 0; k < steps; k++) begin
      if (f == fls_pkg::BASE_NONE || f == 0 || int'(f) - 1 >= used) return fls_pkg::ERR_FRAME;
      f = link_base(word_mem[int'(f) - 1]);
    end
    if (num == 0) return fls_pkg::ERR_LOCAL;
    if (f == fls_pkg::BASE_NONE) return fls_pkg::ERR_FRAME;
    slot = int'(f) + num - 1;
    if (slot >= used) return fls_pkg::ERR_FRAME;
    return fls_pkg::ERR_OK;
  endfunction

  function automatic stack_reply_t execute_stack_op(input fls_pkg::mode_t m,
                                                    input logic [fls_pkg::WORD_BITS-1:0] v,
                                                    input logic [7:0] lc,
                                                    input logic [6:0] fb,
                                                    input logic [7:0] ln);
    stack_reply_t r;
    int           slot;
    r.word = '0;
    r.code = fls_pkg::ERR_OK;
    case (m)
      fls_pkg::MODE_RESET: used = 0;
      fls_pkg::MODE_PUSH: begin
        if (used >= fls_pkg::STACK_DEPTH) begin
          r.code = fls_pkg::ERR_OVER;
        end else begin
          word_mem[used] = v;
          used++;
        end
      end
      fls_pkg::MODE_POP, fls_pkg::MODE_TOP: begin
        if (used == 0) begin
          r.code = fls_pkg::ERR_UNDER;
        end else begin
          r.word = word_mem[used - 1];
          if (m == fls_pkg::MODE_POP) used--;
        end
      end
      fls_pkg::MODE_OPEN: begin
        if (used + 1 + int'(lc) > fls_pkg::STACK_DEPTH) begin
          r.code = fls_pkg::ERR_OVER;
        end else begin
          word_mem[used] = (cur_base == fls_pkg::BASE_NONE) ? '1 :
                           fls_pkg::WORD_BITS'(cur_base);
          used++;
          cur_base = fls_pkg::base_t'(used);
          for (int k = 0; k < int'(lc); k++) begin
            word_mem[used] = '0;
            used++;
          end
        end
      end
      fls_pkg::MODE_READ: begin
        r.code = find_local(int'(fb), int'(ln), slot);
        if (r.code == fls_pkg::ERR_OK) r.word = word_mem[slot];
      end
      fls_pkg::MODE_WRITE: begin
        r.code = find_local(int'(fb), int'(ln), slot);
        if (r.code == fls_pkg::ERR_OK) word_mem[slot] = v;
      end
      default: begin
        if (cur_base == fls_pkg::BASE_NONE || cur_base == 0 || int'(cur_base) > used) begin
          r.code = fls_pkg::ERR_FRAME;
        end else begin
          used     = int'(cur_base) - 1;
          cur_base = link_base(word_mem[used]);
        end
      end
    endcase
    if (r.code != fls_pkg::ERR_OK) r.word = '0;
    r.level = 8'(used);
    return r;
  endfunction

  always @(posedge clk) begin
    stack_reply_t want;
    if (rst) begin
      used     = 0;
      cur_base = fls_pkg::BASE_NONE;
      replies_due.delete();
    end else begin
      if (done) begin
        if (replies_due.size() == 0) begin
          report("reply with no request due", 32'(depth), 32'(0));
        end else begin
          want = replies_due.pop_front();
          if (read_value !== want.word) report("read_value", read_value, want.word);
          if (error !== want.code) report("error", 32'(error), 32'(want.code));
          if (depth !== want.level) report("depth", 32'(depth), 32'(want.level));
        end
      end
      if (start && !busy) begin
        replies_due.push_back(execute_stack_op(fls_pkg::mode_t'(mode), value, local_count,
                                               frames_below, local_number));
      end
    end
    pending = replies_due.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// testbench top: clock, reset, stack request stimulus, watchdog and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 780;
  localparam int DRAIN_CYCLES = 300;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [2:0]                    mode;
  logic [fls_pkg::WORD_BITS-1:0] value;
  logic [7:0]                    local_count;
  logic [6:0]                    frames_below;
  logic [7:0]                    local_number;
  logic                          done;
  logic [fls_pkg::WORD_BITS-1:0] read_value;
  logic [2:0]                    error;
  logic [7:0]                    depth;
  int                            fail_count;
  int                            pending;
  int                            idle_cycles;
  int                            burst_left;

  frame_linked_operand_stack i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .value        (value),
    .local_count  (local_count),
    .frames_below (frames_below),
    .local_number (local_number),
    .done         (done),
    .read_value   (read_value),
    .error        (error),
    .depth        (depth)
  );

  stack_op_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .value        (value),
    .local_count  (local_count),
    .frames_below (frames_below),
    .local_number (local_number),
    .done         (done),
    .read_value   (read_value),
    .error        (error),
    .depth        (depth),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("frame_linked_operand_stack: mismatch");
      $finish;
    end
  end

  task automatic send_op(input fls_pkg::mode_t m, input logic [fls_pkg::WORD_BITS-1:0] v,
                         input logic [7:0] lc, input logic [6:0] fb, input logic [7:0] ln);
    int gap;
    int pick;
    start        <= 1'b1;
    mode         <= m;
    value        <= v;
    local_count  <= lc;
    frames_below <= fb;
    local_number <= ln;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      pick = $urandom_range(99);
      if (pick < 3) burst_left = $urandom_range(40, 20);
      gap = (pick < 50) ? 0 : (pick < 90) ? $urandom_range(3, 1) : $urandom_range(40, 6);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int                            pick;
    fls_pkg::mode_t                m;
    logic [fls_pkg::WORD_BITS-1:0] v;
    logic [7:0]                    lc;
    logic [6:0]                    fb;
    logic [7:0]                    ln;
    burst_left   = 0;
    rst          <= 1'b1;
    start        <= 1'b0;
    mode         <= fls_pkg::MODE_RESET;
    value        <= '0;
    local_count  <= '0;
    frames_below <= '0;
    local_number <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty stack and no frame
    send_op(fls_pkg::MODE_POP,   '0, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_TOP,   '0, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_CLOSE, '0, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_READ,  '0, 8'd0, 7'd0, 8'd1);
    send_op(fls_pkg::MODE_READ,  '0, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_WRITE, 32'h1234_5678, 8'd0, 7'd1, 8'd1);
    // plain stack use
    send_op(fls_pkg::MODE_PUSH, '0, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_PUSH, '1, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_TOP,  '0, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_POP,  '0, 8'd0, 7'd0, 8'd0);
    // nested frames and locals
    send_op(fls_pkg::MODE_OPEN,  '0, 8'd3, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_WRITE, 32'hA5A5_A5A5, 8'd0, 7'd0, 8'd1);
    send_op(fls_pkg::MODE_READ,  '0, 8'd0, 7'd0, 8'd1);
    send_op(fls_pkg::MODE_READ,  '0, 8'd0, 7'd0, 8'd4);
    send_op(fls_pkg::MODE_OPEN,  '0, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_WRITE, 32'h5A5A_5A5A, 8'd0, 7'd1, 8'd3);
    send_op(fls_pkg::MODE_READ,  '0, 8'd0, 7'd1, 8'd3);
    send_op(fls_pkg::MODE_READ,  '0, 8'd0, 7'd2, 8'd1);
    send_op(fls_pkg::MODE_CLOSE, '0, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_CLOSE, '0, 8'd0, 7'd0, 8'd0);
    // full stack, widest locals and deepest walk
    send_op(fls_pkg::MODE_OPEN,  '0, 8'd128, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_OPEN,  '0, 8'd127, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_PUSH,  '1, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_READ,  '0, 8'd0, 7'd0, 8'd128);
    send_op(fls_pkg::MODE_READ,  '0, 8'd0, 7'd127, 8'd127);
    // stale frame base after a stack reset
    send_op(fls_pkg::MODE_RESET, '0, 8'd0, 7'd0, 8'd0);
    send_op(fls_pkg::MODE_CLOSE, '0, 8'd0, 7'd0, 8'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(99);
      m = (pick < 2)  ? fls_pkg::MODE_RESET :
          (pick < 22) ? fls_pkg::MODE_PUSH  :
          (pick < 34) ? fls_pkg::MODE_POP   :
          (pick < 40) ? fls_pkg::MODE_TOP   :
          (pick < 54) ? fls_pkg::MODE_OPEN  :
          (pick < 72) ? fls_pkg::MODE_READ  :
          (pick < 86) ? fls_pkg::MODE_WRITE : fls_pkg::MODE_CLOSE;
      pick = $urandom_range(9);
      v = (pick == 0) ? '0 : (pick == 1) ? '1 : fls_pkg::WORD_BITS'($urandom);
      lc = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
      fb = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(2));
      pick = $urandom_range(19);
      ln = (pick == 0) ? 8'd0 : (pick == 1) ? 8'($urandom_range(255)) :
           8'($urandom_range(6, 1));
      send_op(m, v, lc, fb, ln);
    end
    start <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("frame_linked_operand_stack: match");
    end else begin
      $display("frame_linked_operand_stack: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fls_pkg.sv
rtl/fls_ram.sv
rtl/frame_linked_operand_stack.sv
sim/stack_op_checker.sv
sim/tb_top.sv
